FILE: hw/rtl/cartesian_to_polar_top_assert.svh
// assertion macros for cartesian_to_polar_top
`ifndef CARTESIAN_TO_POLAR_TOP_ASSERT_SVH
`define CARTESIAN_TO_POLAR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define C2P_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define C2P_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define C2P_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define C2P_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/c2p_pkg.sv
package c2p_pkg;

   localparam int ANGLE_FRAC   = 30;
   localparam int CORDIC_XW    = 50;
   localparam int ANGLE_W      = 35;
   localparam int ATAN_ENTRIES = 32;

   // pi in q2.30 radians
   localparam logic [ANGLE_W-1:0] PI_Q30 = 35'd3373259426;

   // atan(2^-i) in q2.30 radians
   localparam logic [ANGLE_W-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      35'd843314857, 35'd497837829, 35'd263043837, 35'd133525159,
      35'd67021687,  35'd33543516,  35'd16775851,  35'd8388437,
      35'd4194283,   35'd2097149,   35'd1048576,   35'd524288,
      35'd262144,    35'd131072,    35'd65536,     35'd32768,
      35'd16384,     35'd8192,      35'd4096,      35'd2048,
      35'd1024,      35'd512,       35'd256,       35'd128,
      35'd64,        35'd32,        35'd16,        35'd8,
      35'd4,         35'd2,         35'd1,         35'd0
   };

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REAL_CONNECTED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAG_CONNECTED = 2'd1;

endpackage

FILE: hw/rtl/cartesian_to_polar_top.sv
// Rectangular to polar converter: each transaction carries one complex sample (real and
// imaginary part, signed, SAMPLE_WIDTH bits, Q1.x) and returns its magnitude, the rounded
// integer square root of re^2 + im^2, and its phase atan2(im, re) in signed Q3.x radians,
// clamped to +-pi. One transaction is accepted per clock cycle unless the input is stalled; a
// result passes the entry, square and sum registers and a chain of max(SAMPLE_WIDTH, CORDIC_STAGES)
// iteration stages (each doing up to one CORDIC micro-rotation and one square-root digit) before the output register.
// Back-pressure on the result side fills empty stages before the input stalls.
// Register 0 (real_connected, reset 1) at 0 forces both results to zero; register 1
// (imag_connected, reset 1) at 0 treats the imaginary part as zero.
`include "cartesian_to_polar_top_assert.svh"

module cartesian_to_polar_top
   import c2p_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_real_part,
   input  logic signed [SAMPLE_WIDTH-1:0] req_imag_part,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic        [SAMPLE_WIDTH-1:0] rsp_magnitude,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_phase,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic        [CSR_INDEX_W-1:0]  csr_index,
   input  logic                           csr_wdata
);

   localparam int SQW        = 2 * SAMPLE_WIDTH;
   localparam int NUM_ITER   = (SAMPLE_WIDTH > CORDIC_STAGES) ? SAMPLE_WIDTH : CORDIC_STAGES;
   localparam int PRE_SHIFT  = 47 - SAMPLE_WIDTH;
   localparam int POST_SHIFT = ANGLE_FRAC - (SAMPLE_WIDTH - 3);
   localparam logic signed [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1) << (POST_SHIFT - 1);
   localparam logic signed [ANGLE_W-1:0] PHASE_LIMIT =
      ANGLE_W'((PI_Q30 + ROUND_HALF) >> POST_SHIFT);

   typedef struct packed {
      logic signed [CORDIC_XW-1:0] x;
      logic signed [CORDIC_XW-1:0] y;
      logic signed [ANGLE_W-1:0]   z;
      logic        [SQW-1:0]       rem;
      logic        [SQW-1:0]       root;
      logic                        zero;
   } iter_type;

   // configuration registers
   logic real_conn_ff;
   logic imag_conn_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         real_conn_ff <= 1'b1;
         imag_conn_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REAL_CONNECTED: real_conn_ff <= csr_wdata;
            CSR_IMAG_CONNECTED: imag_conn_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline registers
   logic                           e_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] e_re_ff;
   logic signed [SAMPLE_WIDTH-1:0] e_im_ff;

   logic                        m_valid_ff;
   logic [SQW-1:0]              m_sqre_ff;
   logic [SQW-1:0]              m_sqim_ff;
   logic signed [CORDIC_XW-1:0] m_x_ff;
   logic signed [CORDIC_XW-1:0] m_y_ff;
   logic signed [ANGLE_W-1:0]   m_z_ff;
   logic                        m_zero_ff;

   logic [NUM_ITER:0] it_v_ff;
   iter_type          it_ff [NUM_ITER+1];

   logic                    rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_mag_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_phase_ff;

   // stage readiness, a stage loads when empty or when its successor moves
   logic              out_rdy;
   logic [NUM_ITER:0] it_rdy;
   logic              m_rdy;
   logic              e_rdy;

   assign out_rdy            = !rsp_valid_ff || rsp_ready;
   assign it_rdy[NUM_ITER]   = !it_v_ff[NUM_ITER] || out_rdy;
   assign m_rdy              = !m_valid_ff || it_rdy[0];
   assign e_rdy              = !e_valid_ff || m_rdy;
   assign req_ready          = e_rdy;

   // entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (e_rdy) begin
         e_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (e_rdy && req_valid) begin
         e_re_ff <= real_conn_ff ? req_real_part : '0;
         e_im_ff <= (real_conn_ff && imag_conn_ff) ? req_imag_part : '0;
      end
   end

   // squares and pre-rotation
   logic signed [CORDIC_XW-1:0] x_start;
   logic signed [CORDIC_XW-1:0] y_start;
   logic signed [CORDIC_XW-1:0] m_x_in;
   logic signed [CORDIC_XW-1:0] m_y_in;
   logic signed [ANGLE_W-1:0]   m_z_in;

   always_comb begin
      x_start = CORDIC_XW'(e_re_ff) <<< PRE_SHIFT;
      y_start = CORDIC_XW'(e_im_ff) <<< PRE_SHIFT;
      if (e_re_ff[SAMPLE_WIDTH-1]) begin
         m_x_in = -x_start;
         m_y_in = -y_start;
         m_z_in = e_im_ff[SAMPLE_WIDTH-1] ? -$signed(PI_Q30) : $signed(PI_Q30);
      end else begin
         m_x_in = x_start;
         m_y_in = y_start;
         m_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_rdy) begin
         m_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_rdy && e_valid_ff) begin
         m_sqre_ff <= SQW'(e_re_ff * e_re_ff);
         m_sqim_ff <= SQW'(e_im_ff * e_im_ff);
         m_x_ff    <= m_x_in;
         m_y_ff    <= m_y_in;
         m_z_ff    <= m_z_in;
         m_zero_ff <= (e_re_ff == '0) && (e_im_ff == '0);
      end
   end

   // sum of squares, start of the iteration chain
   always_ff @(posedge clock) begin
      if (reset) begin
         it_v_ff[0] <= 1'b0;
      end else if (it_rdy[0]) begin
         it_v_ff[0] <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (it_rdy[0] && m_valid_ff) begin
         it_ff[0].x    <= m_x_ff;
         it_ff[0].y    <= m_y_ff;
         it_ff[0].z    <= m_z_ff;
         it_ff[0].rem  <= m_sqre_ff + m_sqim_ff;
         it_ff[0].root <= '0;
         it_ff[0].zero <= m_zero_ff;
      end
   end

   // up to one micro-rotation and one root digit per stage
   for (genvar k = 0; k < NUM_ITER; k++) begin : g_iter
      localparam bit DO_ROT  = k < CORDIC_STAGES;
      localparam bit DO_ROOT = k < SAMPLE_WIDTH;
      localparam logic [SQW-1:0] ROOT_BIT =
         DO_ROOT ? (SQW'(1) << (DO_ROOT ? 2 * (SAMPLE_WIDTH - 1 - k) : 0)) : '0;

      iter_type     cur;
      iter_type     nxt;
      logic [SQW:0] trial;

      assign it_rdy[k] = !it_v_ff[k] || it_rdy[k+1];

      always_comb begin
         cur   = it_ff[k];
         nxt   = cur;
         trial = {1'b0, cur.root} + {1'b0, ROOT_BIT};
         if (DO_ROT) begin
            if (!cur.y[CORDIC_XW-1]) begin
               nxt.x = cur.x + (cur.y >>> k);
               nxt.y = cur.y - (cur.x >>> k);
               nxt.z = cur.z + $signed(ATAN_Q30[k]);
            end else begin
               nxt.x = cur.x - (cur.y >>> k);
               nxt.y = cur.y + (cur.x >>> k);
               nxt.z = cur.z - $signed(ATAN_Q30[k]);
            end
         end
         if (DO_ROOT) begin
            if ({1'b0, cur.rem} >= trial) begin
               nxt.rem  = cur.rem - trial[SQW-1:0];
               nxt.root = (cur.root >> 1) + ROOT_BIT;
            end else begin
               nxt.root = cur.root >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            it_v_ff[k+1] <= 1'b0;
         end else if (it_rdy[k+1]) begin
            it_v_ff[k+1] <= it_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (it_rdy[k+1] && it_v_ff[k]) begin
            it_ff[k+1] <= nxt;
         end
      end
   end

   // rounding, clamp and output register
   logic                         round_up;
   logic [SAMPLE_WIDTH:0]        mag_sum;
   logic signed [ANGLE_W-1:0]    phase_round;
   logic signed [ANGLE_W-1:0]    phase_clamp;
   logic [SAMPLE_WIDTH-1:0]      rsp_mag_in;
   logic [SAMPLE_WIDTH-1:0]      rsp_phase_in;

   always_comb begin
      round_up    = it_ff[NUM_ITER].rem > it_ff[NUM_ITER].root;
      mag_sum     = {1'b0, it_ff[NUM_ITER].root[SAMPLE_WIDTH-1:0]}
                    + {{SAMPLE_WIDTH{1'b0}}, round_up};
      rsp_mag_in  = mag_sum[SAMPLE_WIDTH-1:0];
      phase_round = (it_ff[NUM_ITER].z + ROUND_HALF) >>> POST_SHIFT;
      if (it_ff[NUM_ITER].zero) begin
         phase_clamp = '0;
      end else if (phase_round > PHASE_LIMIT) begin
         phase_clamp = PHASE_LIMIT;
      end else if (phase_round < -PHASE_LIMIT) begin
         phase_clamp = -PHASE_LIMIT;
      end else begin
         phase_clamp = phase_round;
      end
      rsp_phase_in = phase_clamp[SAMPLE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= it_v_ff[NUM_ITER];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && it_v_ff[NUM_ITER]) begin
         rsp_mag_ff   <= rsp_mag_in;
         rsp_phase_ff <= rsp_phase_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_phase     = $signed(rsp_phase_ff);

   // checks
   `C2P_ASSERT_NEXT(a_entry_load, clock, reset, req_valid && req_ready, e_valid_ff, "accepted transaction not captured")
   `C2P_ASSERT_NEXT(a_tail_hold, clock, reset, it_v_ff[NUM_ITER] && rsp_valid_ff && !rsp_ready, it_v_ff[NUM_ITER] && $stable(it_ff[NUM_ITER]), "last stage lost data on stall")
   `C2P_ASSERT_IMPLY(a_zero_phase, clock, reset, rsp_valid_ff && (rsp_mag_ff == '0), rsp_phase_ff == '0, "zero magnitude with nonzero phase")
   `C2P_ASSERT_IMPLY(a_phase_range, clock, reset, rsp_valid_ff, ($signed(rsp_phase_ff) <= PHASE_LIMIT) && ($signed(rsp_phase_ff) >= -PHASE_LIMIT), "phase outside +-pi")

endmodule
